// ===== src/d8rfd_pkg.sv =====
package d8rfd_pkg;

    // default and range of the line store depth
    localparam int MAX_COLS_DEF = 4096;
    localparam int MIN_COLS     = 3;

    // field and register widths
    localparam int CODE_W      = 8;
    localparam int NUM_COLS_W  = 13;
    localparam int NUM_ROWS_W  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    // register reset values
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 13'd4096;
    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 16'd3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } cfg_reg_t;

    // item kinds carried on s_tuser
    typedef enum logic {
        FUNC_CELL  = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic              emit;
        logic              frame_end;
        logic [2:0]        row_ok;    // source row above, level, below lies in the interior
        logic [2:0]        col_ok;    // source column left, level, right lies in the interior
        logic [CODE_W-1:0] upper;
        logic [CODE_W-1:0] middle;
        logic [CODE_W-1:0] code;
    } entry_t;

    // D8 sources: window row and column of the source, its code, bit set in the centre
    localparam logic [1:0] SRC_WR [8] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] SRC_WC [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};
    localparam logic [CODE_W-1:0] SRC_CODE [8] =
        '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128};
    localparam logic [CODE_W-1:0] SET_BIT [8] =
        '{8'd16, 8'd32, 8'd64, 8'd128, 8'd1, 8'd2, 8'd4, 8'd8};

endpackage

// ===== src/d8rfd_front.sv =====
module d8rfd_front #(
    parameter int MAX_COLS = d8rfd_pkg::MAX_COLS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [d8rfd_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [d8rfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input beats
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic                                    s_tuser,
    input  logic [d8rfd_pkg::CODE_W-1:0]            s_tdata,
    // queue side
    input  logic [$clog2(d8rfd_pkg::QUEUE_DEPTH+1)-1:0] q_count,
    output logic                                    push,
    output d8rfd_pkg::entry_t                       push_entry
);

    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW  = (CW > d8rfd_pkg::NUM_COLS_W) ? CW : d8rfd_pkg::NUM_COLS_W;
    localparam int TW  = d8rfd_pkg::NUM_ROWS_W + CW;
    localparam int QCW = $clog2(d8rfd_pkg::QUEUE_DEPTH + 1);
    localparam int RW  = d8rfd_pkg::NUM_ROWS_W;
    // clamped width that the reset value of num_cols stands for
    localparam int COLS_RST = (int'(d8rfd_pkg::NUM_COLS_RST) > MAX_COLS) ?
                              MAX_COLS : int'(d8rfd_pkg::NUM_COLS_RST);

    logic [d8rfd_pkg::NUM_COLS_W-1:0] num_cols_reg;
    logic [RW-1:0]                    num_rows_reg;
    logic [CW-1:0]                    cols_eff_reg, cols_clamp;
    logic [TW-1:0]                    total_reg, total_next;
    logic [1:0]                       busy_reg;
    logic                             cfg_fire;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [TW-1:0] cnt_reg, cnt_next;

    logic                             accept;
    logic [CW-1:0]                    c0, c, c_plus, cc;
    logic [RW-1:0]                    r0, r, r_plus, cr;
    logic [TW-1:0]                    n0, n1;
    logic                             restart, emit, fend, done;
    logic [2:0]                       row_ok, col_ok;
    logic [d8rfd_pkg::CODE_W-1:0]     code;
    logic [NW-1:0]                    ncols_ext;
    logic [RW+1:0]                    cr_x, rows_x;
    logic [CW+1:0]                    cc_x, cols_x;

    // memories and first stage
    logic [d8rfd_pkg::CODE_W-1:0] upper_mem  [MAX_COLS];
    logic [d8rfd_pkg::CODE_W-1:0] middle_mem [MAX_COLS];
    logic [d8rfd_pkg::CODE_W-1:0] rd_upper_reg, rd_middle_reg;
    logic                         s1_valid_reg;
    logic                         s1_emit_reg, s1_fend_reg;
    logic [2:0]                   s1_row_ok_reg, s1_col_ok_reg;
    logic [d8rfd_pkg::CODE_W-1:0] s1_code_reg;
    logic [AW-1:0]                s1_idx_reg;
    logic [QCW:0]                 occ;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= d8rfd_pkg::NUM_COLS_RST;
            num_rows_reg <= d8rfd_pkg::NUM_ROWS_RST;
        end else if (cfg_fire) begin
            case (d8rfd_pkg::cfg_reg_t'(cfg_addr))
                d8rfd_pkg::REG_NUM_COLS: begin
                    num_cols_reg <= cfg_data[d8rfd_pkg::NUM_COLS_W-1:0];
                end
                d8rfd_pkg::REG_NUM_ROWS: begin
                    num_rows_reg <= cfg_data[RW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // width clamp and frame size, registered in cols_eff_reg and then in total_reg
    always_comb begin
        ncols_ext = NW'(num_cols_reg);
        if (ncols_ext < NW'(d8rfd_pkg::MIN_COLS)) begin
            cols_clamp = CW'(d8rfd_pkg::MIN_COLS);
        end else if (ncols_ext > NW'(MAX_COLS)) begin
            cols_clamp = CW'(MAX_COLS);
        end else begin
            cols_clamp = CW'(ncols_ext);
        end
        total_next = TW'(num_rows_reg) * TW'(cols_eff_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_eff_reg <= CW'(COLS_RST);
            total_reg    <= TW'(d8rfd_pkg::NUM_ROWS_RST) * TW'(COLS_RST);
            busy_reg     <= 2'b00;
        end else begin
            cols_eff_reg <= cols_clamp;
            total_reg    <= total_next;
            busy_reg     <= {busy_reg[0], cfg_fire};
        end
    end

    // hold off input while the frame size settles and while the queue lacks room
    assign occ      = (QCW+1)'(q_count) + (QCW+1)'(s1_valid_reg);
    assign s_tready = (busy_reg == 2'b00) && (occ < (QCW+1)'(d8rfd_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid & s_tready;

    // raster position of the beat and classification
    always_comb begin
        code    = (s_tuser == d8rfd_pkg::FUNC_DRAIN) ? '0 : s_tdata;
        restart = (cnt_reg >= total_reg);
        c0      = restart ? '0 : col_reg;
        r0      = restart ? '0 : row_reg;
        n0      = restart ? '0 : cnt_reg;
        if (c0 >= cols_eff_reg) begin
            c = '0;
            r = r0 + RW'(1);
        end else begin
            c = c0;
            r = r0;
        end
        emit = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
        n1   = n0 + TW'(emit);
        fend = emit && (n1 == total_reg);
        done = emit && (n1 >= total_reg);

        c_plus = c + CW'(1);
        r_plus = r + RW'(1);
        if (done) begin
            col_next = '0;
            row_next = '0;
            cnt_next = '0;
        end else if (c_plus >= cols_eff_reg) begin
            col_next = '0;
            row_next = r_plus;
            cnt_next = n1;
        end else begin
            col_next = c_plus;
            row_next = r;
            cnt_next = n1;
        end

        // centre cell of the window
        if (c != '0) begin
            cc = c - CW'(1);
            cr = r - RW'(1);
        end else begin
            cc = cols_eff_reg - CW'(1);
            cr = r - RW'(2);
        end

        // interior tests for the three source rows and columns
        cr_x   = (RW+2)'(cr);
        rows_x = (RW+2)'(num_rows_reg);
        cc_x   = (CW+2)'(cc);
        cols_x = (CW+2)'(cols_eff_reg);
        row_ok[0] = (cr_x >= (RW+2)'(2)) && (cr_x + (RW+2)'(1) <= rows_x);
        row_ok[1] = (cr_x >= (RW+2)'(1)) && (cr_x + (RW+2)'(2) <= rows_x);
        row_ok[2] = (cr_x + (RW+2)'(3) <= rows_x);
        col_ok[0] = (cc_x >= (CW+2)'(2)) && (cc_x + (CW+2)'(1) <= cols_x);
        col_ok[1] = (cc_x >= (CW+2)'(1)) && (cc_x + (CW+2)'(2) <= cols_x);
        col_ok[2] = (cc_x + (CW+2)'(3) <= cols_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // first stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg   <= emit;
            s1_fend_reg   <= fend;
            s1_row_ok_reg <= row_ok;
            s1_col_ok_reg <= col_ok;
            s1_code_reg   <= code;
            s1_idx_reg    <= c[AW-1:0];
        end
    end

    // line stores: read old value, middle written on accept, upper in the cycle after
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_upper_reg          <= upper_mem[c[AW-1:0]];
            rd_middle_reg         <= middle_mem[c[AW-1:0]];
            middle_mem[c[AW-1:0]] <= code;
        end
        if (s1_valid_reg) begin
            upper_mem[s1_idx_reg] <= rd_middle_reg;
        end
    end

    // hand over to the queue
    assign push = s1_valid_reg;
    always_comb begin
        push_entry.emit      = s1_emit_reg;
        push_entry.frame_end = s1_fend_reg;
        push_entry.row_ok    = s1_row_ok_reg;
        push_entry.col_ok    = s1_col_ok_reg;
        push_entry.upper     = rd_upper_reg;
        push_entry.middle    = rd_middle_reg;
        push_entry.code      = s1_code_reg;
    end

endmodule

// ===== src/d8rfd_queue.sv =====
module d8rfd_queue (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        push,
    input  d8rfd_pkg::entry_t                           push_entry,
    input  logic                                        pop,
    output logic                                        q_valid,
    output d8rfd_pkg::entry_t                           q_entry,
    output logic [$clog2(d8rfd_pkg::QUEUE_DEPTH+1)-1:0] q_count
);

    localparam int DEPTH = d8rfd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int QCW   = $clog2(DEPTH + 1);

    d8rfd_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]    count_reg;

    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];
    assign q_count = count_reg;

    // pointers and fill level; the front never pushes into a full queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/d8rfd_back.sv =====
module d8rfd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  d8rfd_pkg::entry_t            q_entry,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [d8rfd_pkg::CODE_W-1:0] m_tdata,
    output logic                         m_tlast
);

    logic [d8rfd_pkg::CODE_W-1:0] last1_reg [3];   // column loaded one item ago
    logic [d8rfd_pkg::CODE_W-1:0] last2_reg [3];   // column loaded two items ago
    logic [d8rfd_pkg::CODE_W-1:0] win [3][3];
    logic [d8rfd_pkg::CODE_W-1:0] mask;
    logic                         m_tvalid_reg;
    logic [d8rfd_pkg::CODE_W-1:0] m_tdata_reg;
    logic                         m_tlast_reg;

    assign pop      = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // window after the shift, new column on the right
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win[i][0] = last2_reg[i];
            win[i][1] = last1_reg[i];
        end
        win[0][2] = q_entry.upper;
        win[1][2] = q_entry.middle;
        win[2][2] = q_entry.code;
    end

    // each source that points at the centre sets its opposite bit
    always_comb begin
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (q_entry.row_ok[d8rfd_pkg::SRC_WR[i]] && q_entry.col_ok[d8rfd_pkg::SRC_WC[i]] &&
                (win[d8rfd_pkg::SRC_WR[i]][d8rfd_pkg::SRC_WC[i]] == d8rfd_pkg::SRC_CODE[i])) begin
                mask = mask | d8rfd_pkg::SET_BIT[i];
            end
        end
    end

    // window shift on every item taken from the queue
    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                last2_reg[i] <= last1_reg[i];
            end
            last1_reg[0] <= q_entry.upper;
            last1_reg[1] <= q_entry.middle;
            last1_reg[2] <= q_entry.code;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop && q_entry.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_entry.emit) begin
            m_tdata_reg <= mask;
            m_tlast_reg <= q_entry.frame_end;
        end
    end

endmodule

// ===== src/d8_reverse_flow_direction.sv =====
// Channel  Dir  Handshake             tdata            tuser / tlast
// cfg      in   cfg_valid/cfg_ready   cfg_data [15:0]  cfg_addr: 0 num_cols, 1 num_rows
// s_       in   s_tvalid/s_tready     direction_code   s_tuser: func
// m_       out  m_tvalid/m_tready     inflow_mask      m_tlast: frame_end
//
// One item per clock while m_tready is high and no configuration write settles; an
// accepted beat passes the line store read stage and the queue on its way to the
// output register. The mask for cell k leaves with beat k+num_cols+1. After a
// configuration write s_tready stays low while the width clamp and the frame size
// multiply settle. Reset clears control state only; the line stores need no clearing
// pass. With m_tready low the four-entry queue fills and s_tready drops.
module d8_reverse_flow_direction #(
    parameter int MAX_COLS = d8rfd_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [d8rfd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [d8rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,   // [0] func
    input  logic [d8rfd_pkg::CODE_W-1:0]      s_tdata,   // [7:0] direction_code
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [d8rfd_pkg::CODE_W-1:0]      m_tdata,   // [7:0] inflow_mask
    output logic                              m_tlast    // frame_end
);

    logic                                            push, pop, q_valid;
    d8rfd_pkg::entry_t                               push_entry, q_entry;
    logic [$clog2(d8rfd_pkg::QUEUE_DEPTH+1)-1:0]     q_count;

    // position tracking, classification and line stores
    d8rfd_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    d8rfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_count    (q_count)
    );

    // 3x3 window and mask
    d8rfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/sv/tb_d8_reverse_flow_direction.sv =====
module tb_d8_reverse_flow_direction;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 1600;

    localparam int CODE_W       = d8rfd_pkg::CODE_W;
    localparam int CFG_DATA_W   = d8rfd_pkg::CFG_DATA_W;
    localparam int NUM_COLS_W   = d8rfd_pkg::NUM_COLS_W;
    localparam int MAX_COLS_DEF = d8rfd_pkg::MAX_COLS_DEF;
    localparam int MIN_COLS     = d8rfd_pkg::MIN_COLS;

    // one expected output beat
    typedef struct {
        logic [CODE_W-1:0] mask;
        logic              frame_end;
    } inflow_t;

    // Raster model: line stores, 3x3 window and stream position, plus the
    // queue of inflow masks still owed by the block.
    class inflow_scoreboard;
        int unsigned       width_reg;
        int unsigned       height_reg;
        logic [CODE_W-1:0] upper_line [MAX_COLS_DEF];
        logic [CODE_W-1:0] middle_line [MAX_COLS_DEF];
        logic [CODE_W-1:0] win [3][3];
        int unsigned       col_pos;
        int unsigned       row_pos;
        int unsigned       emitted;
        int unsigned       frames_done;
        int unsigned       failures;
        inflow_t           due_masks [$];

        function new();
            width_reg   = d8rfd_pkg::NUM_COLS_RST;
            height_reg  = d8rfd_pkg::NUM_ROWS_RST;
            frames_done = 0;
            failures    = 0;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            clear_frame();
        endfunction

        function void clear_frame();
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
            foreach (win[r, c]) win[r][c] = '0;
        endfunction

        function int unsigned width_eff();
            if (width_reg < MIN_COLS) return MIN_COLS;
            if (width_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
            return width_reg;
        endfunction

        // row that the next beat will land in
        function int unsigned next_row();
            if (emitted >= height_reg * width_eff()) return 0;
            if (col_pos >= width_eff()) return row_pos + 1;
            return row_pos;
        endfunction

        function void write_reg(d8rfd_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == d8rfd_pkg::REG_NUM_COLS) width_reg = value[NUM_COLS_W-1:0];
            else height_reg = value;
        endfunction

        // shift one code into the window and work out the mask of the centre cell
        function void note_cell(d8rfd_pkg::func_t kind, logic [CODE_W-1:0] data);
            int unsigned       cols;
            int unsigned       total;
            int unsigned       col;
            int unsigned       row;
            int                cr;
            int                cc;
            int                i;
            int                row_off [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
            int                col_off [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
            logic [CODE_W-1:0] code;
            logic [CODE_W-1:0] mask;
            bit                produced;

            cols     = width_eff();
            total    = height_reg * cols;
            code     = (kind == d8rfd_pkg::FUNC_DRAIN) ? '0 : data;
            produced = 1'b0;

            if (emitted >= total) clear_frame();
            if (col_pos >= cols) begin
                col_pos = 0;
                row_pos = (row_pos + 1) & 16'hFFFF;
            end
            col = col_pos;
            row = row_pos;

            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2]        = upper_line[col];
            win[1][2]        = middle_line[col];
            win[2][2]        = code;
            upper_line[col]  = middle_line[col];
            middle_line[col] = code;

            if (row >= 2 || (row == 1 && col >= 1)) begin
                // centre sits one row up and one column left, wrapping at the row start
                if (col >= 1) begin
                    cr = int'(row) - 1;
                    cc = int'(col) - 1;
                end else begin
                    cr = int'(row) - 2;
                    cc = int'(cols) - 1;
                end
                mask = '0;
                for (i = 0; i < 8; i++) begin
                    if (cr + row_off[i] >= 1 && cr + row_off[i] <= int'(height_reg) - 2 &&
                        cc + col_off[i] >= 1 && cc + col_off[i] <= int'(cols) - 2 &&
                        win[1 + row_off[i]][1 + col_off[i]] == (8'd1 << i))
                        mask |= 8'd1 << ((i + 4) % 8);
                end
                emitted++;
                due_masks.push_back('{mask, emitted == total});
                if (emitted == total) frames_done++;
                produced = 1'b1;
            end

            if (produced && emitted >= total) begin
                clear_frame();
            end else begin
                col_pos = col + 1;
                if (col_pos >= cols) begin
                    col_pos = 0;
                    row_pos = (row + 1) & 16'hFFFF;
                end
            end
        endfunction

        function void complain(string what);
            failures++;
            if (failures <= 10) $display("%0t: %s", $time, what);
        endfunction

        function void check_beat(logic [CODE_W-1:0] mask, logic frame_end);
            inflow_t want;
            if (due_masks.size() == 0) begin
                complain($sformatf("unexpected beat: inflow_mask %02h frame_end %0b",
                                   mask, frame_end));
                return;
            end
            want = due_masks.pop_front();
            if (mask !== want.mask || frame_end !== want.frame_end)
                complain($sformatf("inflow_mask %02h (exp %02h), frame_end %0b (exp %0b)",
                                   mask, want.mask, frame_end, want.frame_end));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    d8rfd_pkg::cfg_reg_t   cfg_addr  = d8rfd_pkg::REG_NUM_COLS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic                  s_tuser   = d8rfd_pkg::FUNC_CELL;
    logic [CODE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [CODE_W-1:0]     m_tdata;
    logic                  m_tlast;

    inflow_scoreboard board = new();

    int          stall_pct   = 0;
    int          gap_max     = 0;
    int          burst_left  = 0;
    int          ready_run   = 0;
    int          quiet_cycles = 0;
    int unsigned beats_sent  = 0;

    d8_reverse_flow_direction i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // receiver: runs of ready or stall, each of random length
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_run <= 0;
        end else if (ready_run == 0) begin
            m_tready  <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            ready_run <= $urandom_range(1, 12);
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // output beats against the predicted masks
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_beat(m_tdata, m_tlast);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_d8_reverse_flow_direction NOT OK");
            $finish;
        end
    end

    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd247;
            3:       return CODE_W'($urandom_range(255));
            default: return 8'd1 << $urandom_range(7);
        endcase
    endfunction

    // one register beat; cfg_valid is left high for the caller to drop
    task automatic write_reg_beat(d8rfd_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, value);
    endtask

    task automatic program_size(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows);
        write_reg_beat(d8rfd_pkg::REG_NUM_COLS, cols);
        write_reg_beat(d8rfd_pkg::REG_NUM_ROWS, rows);
        cfg_valid <= 1'b0;
    endtask

    // input beat, sent in bursts with random gaps between them
    task automatic push_beat(d8rfd_pkg::func_t kind, logic [CODE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        board.note_cell(kind, data);
        beats_sent++;
    endtask

    // raster cells up to cell_limit (0: whole frame, then the drain beats)
    task automatic send_frame(int cell_limit);
        int unsigned start_frames;
        int          sent;
        start_frames = board.frames_done;
        sent = 0;
        while (board.next_row() < board.height_reg &&
               (cell_limit == 0 || sent < cell_limit)) begin
            if ($urandom_range(24) == 0)
                push_beat(d8rfd_pkg::FUNC_DRAIN, CODE_W'($urandom_range(255)));
            else
                push_beat(d8rfd_pkg::FUNC_CELL, pick_code());
            sent++;
        end
        if (cell_limit == 0) begin
            // mostly drain ticks, now and then a cell code past the frame
            while (board.frames_done == start_frames) begin
                if ($urandom_range(9) == 0)
                    push_beat(d8rfd_pkg::FUNC_CELL, CODE_W'($urandom_range(255)));
                else
                    push_beat(d8rfd_pkg::FUNC_DRAIN, CODE_W'($urandom_range(255)));
            end
        end
    endtask

    // drop valid, wait for every owed mask, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.due_masks.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic pick_pace();
        case ($urandom_range(4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 60;
            default: stall_pct = 85;
        endcase
        case ($urandom_range(2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 8;
        endcase
    endtask

    initial begin
        logic [CODE_W-1:0] probe_codes [15] = '{
            8'd255, 8'd247, 8'd0, 8'd128,
            8'd1, 8'd16, 8'd128, 8'd2,
            8'd4, 8'd1,
            8'd64,
            8'd8, 8'd32, 8'd255, 8'd1
        };
        int unsigned start_beats;
        int unsigned cols;
        int unsigned rows;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 4x4 frame: border extremes, interior sources, a drain tick inside the
        // frame as a sink, and a cell code in place of the last drain beat
        program_size(4, 4);
        for (int i = 0; i < 10; i++) push_beat(d8rfd_pkg::FUNC_CELL, probe_codes[i]);
        push_beat(d8rfd_pkg::FUNC_DRAIN, 8'hA5);
        for (int i = 10; i < 15; i++) push_beat(d8rfd_pkg::FUNC_CELL, probe_codes[i]);
        repeat (4) push_beat(d8rfd_pkg::FUNC_DRAIN, 8'h5A);
        push_beat(d8rfd_pkg::FUNC_CELL, 8'hFF);
        settle();

        // height cut below the count already given: frame restarts
        pick_pace();
        program_size(5, 16'hFFFF);
        send_frame(23);
        settle();
        write_reg_beat(d8rfd_pkg::REG_NUM_ROWS, 3);
        cfg_valid <= 1'b0;
        send_frame(0);
        settle();

        // width cut below the current column: moves on to the next row
        pick_pace();
        program_size(9, 10);
        send_frame(25);
        settle();
        write_reg_beat(d8rfd_pkg::REG_NUM_COLS, 4);
        cfg_valid <= 1'b0;
        send_frame(0);
        settle();

        // width widened part way through a frame
        pick_pace();
        program_size(3, 8);
        send_frame(10);
        settle();
        write_reg_beat(d8rfd_pkg::REG_NUM_COLS, 6);
        cfg_valid <= 1'b0;
        send_frame(0);
        settle();

        // random sizes, one to three frames each, or two to six loose beats for zero rows
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            pick_pace();
            case ($urandom_range(19))
                0:       cols = $urandom_range(0, 2);
                1:       cols = $urandom_range(11, 40);
                2:       cols = MIN_COLS;
                default: cols = $urandom_range(3, 10);
            endcase
            case ($urandom_range(15))
                0:       rows = 0;
                1:       rows = $urandom_range(1, 2);
                2:       rows = $urandom_range(9, 16);
                default: rows = $urandom_range(3, 8);
            endcase
            program_size(CFG_DATA_W'(cols), CFG_DATA_W'(rows));
            if (rows == 0) begin
                repeat ($urandom_range(2, 6))
                    push_beat(d8rfd_pkg::func_t'($urandom_range(1)),
                              CODE_W'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_frame(0);
            end
            settle();
        end

        if (board.failures == 0)
            $display("tb_d8_reverse_flow_direction OK");
        else
            $display("tb_d8_reverse_flow_direction NOT OK");
        $finish;
    end

endmodule
